/* rtl/three_wire_serial_rtc_master_defines.svh */
// Assertion macros shared by the serial clock-chip master.
`ifndef THREE_WIRE_SERIAL_RTC_MASTER_DEFINES_SVH
`define THREE_WIRE_SERIAL_RTC_MASTER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define TWSRTC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TWSRTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/twsrtc_pkg.sv */
`timescale 1ns / 1ps
package twsrtc_pkg;

  localparam int unsigned BitsTotal   = 16;
  localparam int unsigned HalvesTotal = 2 * BitsTotal;
  localparam int unsigned StepW       = 6;
  localparam int unsigned ShiftW      = 16;
  localparam int unsigned ByteW       = 8;
  // The read phase starts after the eight address bits.
  localparam int unsigned ReadStartBit = 8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic              active;
    logic              is_read;
    logic [StepW-1:0]  half_step;
    logic [ShiftW-1:0] out_shift;
    logic [ByteW-1:0]  in_accum;
    logic              clock_level;
    logic [ByteW-1:0]  last_read;
  } state_t;

  typedef struct packed {
    logic             serial_clock;
    logic             data_out;
    logic             data_drive;
    logic             chip_enable;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_raw;
    logic [ByteW-1:0] read_value;
  } result_t;

endpackage

/* rtl/twsrtc_step.sv */
`timescale 1ns / 1ps
module twsrtc_step import twsrtc_pkg::*; (
  input  state_t           state_i,
  input  logic [1:0]       cmd_i,
  input  logic [ByteW-1:0] address_i,
  input  logic [ByteW-1:0] write_data_i,
  input  logic             data_in_i,
  output state_t           state_o,
  output result_t          result_o
);

  logic             low_phase;
  logic             reading;
  logic             ending;
  logic [ByteW-1:0] hi_nib;
  logic [ByteW-1:0] lo_nib;

  assign low_phase = ~state_i.half_step[0];
  assign ending    = state_i.half_step >= StepW'(HalvesTotal);
  assign reading   = state_i.is_read &&
                     (state_i.half_step[StepW-1:1] >= (StepW-1)'(ReadStartBit));

  always_comb begin
    state_o               = state_i;
    result_o              = '0;
    if (state_i.active) begin
      if (ending) begin
        state_o.active      = 1'b0;
        state_o.clock_level = 1'b0;
        state_o.half_step   = '0;
        if (state_i.is_read) begin
          state_o.last_read = state_i.in_accum;
        end
        result_o.done_res   = 1'b1;
      end else begin
        result_o.chip_enable = 1'b1;
        result_o.busy_res    = 1'b1;
        if (reading) begin
          if (low_phase) begin
            state_o.in_accum = {data_in_i, state_i.in_accum[ByteW-1:1]};
          end
        end else begin
          result_o.data_drive = 1'b1;
          result_o.data_out   = state_i.out_shift[0];
          if (!low_phase) begin
            state_o.out_shift = state_i.out_shift >> 1;
          end
        end
        state_o.clock_level = ~low_phase;
        state_o.half_step   = state_i.half_step + StepW'(1);
      end
    end else begin
      case (cmd_i)
        CMD_WRITE, CMD_READ: begin
          state_o.active      = 1'b1;
          state_o.is_read     = (cmd_i == CMD_READ);
          state_o.half_step   = '0;
          state_o.out_shift   = (cmd_i == CMD_READ) ? {{ByteW{1'b0}}, address_i}
                                                    : {write_data_i, address_i};
          state_o.in_accum    = '0;
          state_o.clock_level = 1'b0;
          result_o.chip_enable = 1'b1;
          result_o.busy_res    = 1'b1;
          result_o.data_drive  = 1'b1;
        end
        default: begin
        end
      endcase
    end

    result_o.serial_clock = state_o.clock_level;
    result_o.read_raw     = state_o.last_read;
    // tens * 10 + units, built as tens * 8 + tens * 2 + units.
    hi_nib                = {4'd0, state_o.last_read[7:4]};
    lo_nib                = {4'd0, state_o.last_read[3:0]};
    result_o.read_value   = (hi_nib << 3) + (hi_nib << 1) + lo_nib;
  end

endmodule

/* rtl/three_wire_serial_rtc_master.sv */
`timescale 1ns / 1ps
// Each result is registered when its tick request is taken and appears on the master side in the next cycle.
// Throughput: one tick per clock cycle while the master side does not stall, set by the single registered step logic.
// The output register frees the slave side whenever the master side takes or holds no result.
// Reset: rst_ni low clears the link state to idle, clock low, and the read byte to zero.
`include "three_wire_serial_rtc_master_defines.svh"
module three_wire_serial_rtc_master import twsrtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] address, [15:8] write_data, [16] data_in, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] serial_clock, [1] data_out, [2] data_drive, [3] chip_enable, [4] busy_res,
  // [5] done_res, [13:6] read_raw, [21:14] read_value, [23:22] zero
  output logic [23:0] m_axis_tdata
);

  state_t  state_q, state_d;
  result_t result_d, result_q;
  logic    m_valid_q;
  logic    s_accept;

  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  twsrtc_step u_step (
    .state_i      (state_q),
    .cmd_i        (s_axis_tuser),
    .address_i    (s_axis_tdata[7:0]),
    .write_data_i (s_axis_tdata[15:8]),
    .data_in_i    (s_axis_tdata[16]),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        state_q <= state_d;
      end
      if (s_accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, result_q.read_value, result_q.read_raw, result_q.done_res,
                          result_q.busy_res, result_q.chip_enable, result_q.data_drive,
                          result_q.data_out, result_q.serial_clock};

  `TWSRTC_ASSERT_ALWAYS(a_idle_step_zero, state_q.active || (state_q.half_step == '0), "idle master holds a nonzero half step")
  `TWSRTC_ASSERT_ALWAYS(a_step_bound, state_q.half_step <= StepW'(HalvesTotal), "half step ran past the end of the transfer")
  `TWSRTC_ASSERT_NEXT(a_read_start, s_accept && !state_q.active && (s_axis_tuser == CMD_READ), state_q.active && state_q.is_read && (state_q.in_accum == '0), "read request did not start a read transfer")
  `TWSRTC_ASSERT_NEXT(a_end_idle, s_accept && state_q.active && (state_q.half_step == StepW'(HalvesTotal)), !state_q.active && m_valid_q && result_q.done_res, "ending tick did not return to idle with done")

endmodule
